FILE: hw/rtl/pba_pkg.sv
// Package for the packed bit array block: payload structs, controller
// state type, command and status bundles, entries-per-word table.
// No dependencies.
`timescale 1ns / 1ps

package pba_pkg;

  localparam int PBA_WORD_COUNT = 1024;
  localparam int PBA_WORD_BITS  = 64;
  localparam logic [63:0] PBA_ALL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [6:0]  PBA_WIDTH_RESET = 7'd4;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } pba_req_type_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] index;
    logic [63:0] write_value;
  } pba_req_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        out_of_range;
  } pba_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_CALC,
    ST_ACCESS,
    ST_RESP
  } pba_state_t;

  typedef struct packed {
    logic clr_step;  // write zero at clear pointer, advance it
    logic capture;   // latch request, start divider
    logic calc;      // form bit offset, range check, issue word read
    logic access;    // merge or extract, commit write
  } pba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
  } pba_sts_t;

  // floor(64 / w) for an effective width w of 1..64
  function automatic logic [6:0] per_word(input logic [6:0] w);
    logic [6:0] r;
    case (w) inside
      7'd1:          r = 7'd64;
      7'd2:          r = 7'd32;
      7'd3:          r = 7'd21;
      7'd4:          r = 7'd16;
      7'd5:          r = 7'd12;
      7'd6:          r = 7'd10;
      7'd7:          r = 7'd9;
      7'd8:          r = 7'd8;
      7'd9:          r = 7'd7;
      7'd10:         r = 7'd6;
      [7'd11:7'd12]: r = 7'd5;
      [7'd13:7'd16]: r = 7'd4;
      [7'd17:7'd21]: r = 7'd3;
      [7'd22:7'd32]: r = 7'd2;
      default:       r = 7'd1;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/packed_bit_array_access.sv
// Packed bit array access: 64-bit words hold floor(64/width) entries each.
// One transaction at a time; start is taken again in the idle cycle that
// follows the done strobe. The 16-step index divider takes up most of each
// transaction.
// Reset: synchronous, active high; afterwards a clearing pass zeroes every
// memory word with busy high. The receiver cannot stall.
`timescale 1ns / 1ps

module packed_bit_array_access #(
  parameter int WORD_COUNT = pba_pkg::PBA_WORD_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  // request channel: accepted when start is high and busy is low
  input  logic              start,
  output logic              busy,
  input  pba_pkg::pba_req_t req,
  // result channel: valid for the single cycle that done is high
  output logic              done,
  output pba_pkg::pba_rsp_t rsp,
  // entry width register
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata
);
  import pba_pkg::*;

  // Sequence per transaction:
  //   capture     - request latched, divider loaded with index / entries-per-word
  //   divide      - 16 iterations, then wait for the registered divider done
  //   calc        - bit offset = remainder * width, range check, word read issued
  //   access      - registered word merged and written back, or entry extracted
  //   respond     - done strobe, result registers on rsp
  // An out-of-range word leaves memory untouched and reports zero data.

  pba_cmd_t cmd;
  pba_sts_t sts;

  pba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // The user must change the width register only while idle (not enforced here); the datapath reads it live.
  pba_datapath #(
    .WORD_COUNT (WORD_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp       (rsp)
  );

endmodule

FILE: hw/rtl/pba_div.sv
// Restoring divider, one quotient bit per cycle: 16-bit entry index over
// 7-bit entries-per-word. Depends on nothing but clk/rst.
`timescale 1ns / 1ps

module pba_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [6:0]  divisor,
  output logic        done,
  output logic [15:0] quotient,
  output logic [5:0]  remainder
);

  logic [15:0] quot;
  logic [6:0]  rem;
  logic [6:0]  dvsr;
  logic [4:0]  cnt;
  logic        run;
  logic [7:0]  trial;
  logic        fits;

  assign trial = {rem, quot[15]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 5'd16;
      end else if (run) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= 7'd0;
      dvsr <= divisor;
    end else if (run) begin
      if (fits) begin
        rem  <= 7'(trial - {1'b0, dvsr});
        quot <= {quot[14:0], 1'b1};
      end else begin
        rem  <= trial[6:0];
        quot <= {quot[14:0], 1'b0};
      end
    end
  end

  assign quotient  = quot;
  assign remainder = rem[5:0];  // below divisor, so at most 63

endmodule

FILE: hw/rtl/pba_ctrl.sv
// Controller FSM for the packed bit array: clearing pass, divide wait,
// access sequencing, result strobe. Depends on pba_pkg.
`timescale 1ns / 1ps

module pba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pba_pkg::pba_sts_t sts,
  output pba_pkg::pba_cmd_t cmd,
  output logic              busy,
  output logic              done
);
  import pba_pkg::*;

  pba_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_ACCESS;
      end
      ST_ACCESS: begin
        cmd.access = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/pba_datapath.sv
// Datapath for the packed bit array: width register, word memory with
// clear pointer, divider, offset multiply, read-modify-write merge.
// Depends on pba_pkg and pba_div.
`timescale 1ns / 1ps

module pba_datapath #(
  parameter int WORD_COUNT = pba_pkg::PBA_WORD_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  pba_pkg::pba_cmd_t cmd,
  output pba_pkg::pba_sts_t sts,
  input  pba_pkg::pba_req_t req,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  output pba_pkg::pba_rsp_t rsp
);
  import pba_pkg::*;

  localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  logic [63:0] mem [0:WORD_COUNT-1];

  logic [6:0]    bits_per_entry;
  logic [6:0]    w_eff;
  logic [63:0]   mask;
  logic [AW-1:0] clr_ptr;
  pba_req_t      req_q;
  logic          div_done;
  logic [15:0]   quot;
  logic [5:0]    rem;
  logic [12:0]   prod;
  logic [5:0]    shift;
  logic          oor;
  logic [AW-1:0] word_addr;
  logic [63:0]   rdata;
  logic [63:0]   field_mask;
  logic [63:0]   merged;
  pba_rsp_t      rsp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_entry <= PBA_WIDTH_RESET;
    end else if (cfg_we) begin
      bits_per_entry <= cfg_wdata;
    end
  end

  always_comb begin
    if (bits_per_entry == 7'd0) begin
      w_eff = 7'd1;
    end else if (bits_per_entry > 7'd64) begin
      w_eff = 7'd64;
    end else begin
      w_eff = bits_per_entry;
    end
  end

  // shift by 64 empties the word, so full width gives all ones
  assign mask = ~(PBA_ALL_ONES << w_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clr_step) begin
      clr_ptr <= clr_ptr + AW'(1);
    end
  end

  assign sts.clr_last = clr_ptr == AW'(WORD_COUNT - 1);

  always_ff @(posedge clk) begin
    if (cmd.capture) req_q <= req;
  end

  pba_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.capture),
    .dividend  (req.index),
    .divisor   (per_word(w_eff)),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  assign sts.div_done = div_done;

  assign prod      = {7'd0, rem} * {6'd0, w_eff};
  assign word_addr = quot[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      shift <= prod[5:0];  // offset stays below 64
      oor   <= {1'b0, quot} >= 17'(WORD_COUNT);
    end
  end

  assign field_mask = mask << shift;
  assign merged     = (rdata & ~field_mask) | ((req_q.write_value & mask) << shift);

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_ptr] <= 64'd0;
    end else if (cmd.access && !oor && req_q.req_type == REQ_WRITE) begin
      mem[word_addr] <= merged;
    end
    if (cmd.calc) begin
      rdata <= mem[word_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      rsp_q.out_of_range <= oor;
      if (oor || req_q.req_type == REQ_WRITE) begin
        rsp_q.read_data <= 64'd0;
      end else begin
        rsp_q.read_data <= (rdata >> shift) & mask;
      end
    end
  end

  assign rsp = rsp_q;

endmodule

FILE: sim/tb_top.sv
// Self-checking bench for the packed bit array access block (pba_pkg and
// packed_bit_array_access): a directed table, then random transactions
// against a shadow copy of the packed store.
`timescale 1ns / 1ps

module tb_top;
  import pba_pkg::*;

  localparam int          WORDS       = PBA_WORD_COUNT;
  localparam int          N_RANDOM    = 1430;
  localparam int          MAX_REPORTS = 10;
  localparam int          TAIL_CYCLES = 30;    // idle tail after the final drain
  localparam int          HOT_DEPTH   = 16;

  // Directed table row: width to program, request, optional typed-in result
  typedef struct {
    logic [6:0] width;
    pba_req_t   r;
    bit         typed;
    pba_rsp_t   rsp;
  } dir_row_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  logic       busy;
  pba_req_t   req       = '0;
  logic       done;
  pba_rsp_t   rsp;
  logic       cfg_we    = 1'b0;
  logic [6:0] cfg_wdata = '0;

  // Shadow of the block: packed store plus width register
  logic [63:0] shadow_words [WORDS];
  logic [6:0]  shadow_width;

  pba_rsp_t    entry_rsp_q [$];   // results still owed by the block, oldest first
  dir_row_t    dir_rows    [$];
  logic [15:0] hot_idx     [$];   // recently written indices, for read-back
  bit          no_idle;
  int unsigned fail_count   = 0;
  int unsigned report_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  packed_bit_array_access #(
    .WORD_COUNT(WORDS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Register value to effective width: zero acts as 1, anything over 64 as 64
  function automatic int unsigned eff_width(input logic [6:0] v);
    if (v < 7'd1) return 1;
    if (v > 7'd64) return 64;
    return 32'(v);
  endfunction

  // Apply one transaction to the shadow store and return the result it owes.
  // Words are never repacked on a width change, so old bits are simply
  // reinterpreted at the new width.
  function automatic pba_rsp_t access_entry(input pba_req_t r);
    int unsigned w, per, word, shift;
    logic [63:0] m;
    pba_rsp_t    res;
    w     = eff_width(shadow_width);
    m     = (w == 64) ? PBA_ALL_ONES : ((64'd1 << w) - 64'd1);
    per   = 64 / w;                 // entries never straddle a word
    word  = r.index / per;
    shift = (r.index % per) * w;
    res   = '0;
    if (word >= WORDS) begin
      // past the memory: flag only, store untouched for reads and writes
      res.out_of_range = 1'b1;
    end else if (r.req_type == REQ_WRITE) begin
      shadow_words[word] = (shadow_words[word] & ~(m << shift))
                         | ((r.write_value & m) << shift);
    end else begin
      res.read_data = (shadow_words[word] >> shift) & m;
    end
    return res;
  endfunction

  task automatic note_failure(input string what, input pba_rsp_t want, input pba_rsp_t got);
    fail_count++;
    if (report_count < MAX_REPORTS) begin
      report_count++;
      $display("%0t %s: read_data exp %h got %h, out_of_range exp %b got %b",
               $realtime, what, want.read_data, got.read_data,
               want.out_of_range, got.out_of_range);
    end
  endtask

  // Result monitor: done is a one-cycle strobe, sampled at the edge ending it
  always @(posedge clk) begin : result_check
    pba_rsp_t want;
    if (!rst && done) begin
      if (entry_rsp_q.size() == 0) begin
        note_failure("unexpected result", '0, rsp);
      end else begin
        want = entry_rsp_q.pop_front();
        if (rsp.read_data !== want.read_data || rsp.out_of_range !== want.out_of_range)
          note_failure("result mismatch", want, rsp);
      end
    end
  end

  // Present one transaction and hold it until busy lets it in. The
  // expectation is formed at the accepting edge. A gap may follow, during
  // which the request bus carries junk with start low.
  task automatic issue_request(input pba_req_t r, input bit typed, input pba_rsp_t typed_rsp);
    pba_rsp_t    want;
    pba_req_t    junk;
    int unsigned gap, pick;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    want = access_entry(r);
    if (typed) want = typed_rsp;
    entry_rsp_q.push_back(want);
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 40) gap = 0;
    else if (pick < 85)       gap = $urandom_range(1, 4);
    else if (pick < 97)       gap = $urandom_range(5, 25);
    else                      gap = $urandom_range(30, 80);
    if (gap != 0) begin
      junk  = {1'($urandom), 16'($urandom), $urandom, $urandom};
      start <= 1'b0;
      req   <= junk;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Every transaction owes exactly one result, so an empty queue means idle
  task automatic drain_results();
    start <= 1'b0;
    while (entry_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_width(input logic [6:0] v);
    cfg_we       <= 1'b1;
    cfg_wdata    <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    shadow_width = v;
    // let the per-word table settle before the next transaction
    repeat (2) @(posedge clk);
  endtask

  function automatic void add_row(input logic [6:0] w, input pba_req_type_t t,
                                  input logic [15:0] idx, input logic [63:0] val,
                                  input bit typed, input logic [63:0] exp_data,
                                  input logic exp_oor);
    dir_row_t row;
    row.width              = w;
    row.r.req_type         = t;
    row.r.index            = idx;
    row.r.write_value      = val;
    row.typed              = typed;
    row.rsp.read_data      = exp_data;
    row.rsp.out_of_range   = exp_oor;
    dir_rows.push_back(row);
  endfunction

  // Stimulus
  initial begin : stimulus
    pba_req_t    r;
    pba_rsp_t    none;
    logic [6:0]  wsel;
    int unsigned w, cap, pick, phase_len, sent;

    none         = '0;
    no_idle      = 1'b0;
    shadow_width = PBA_WIDTH_RESET;
    foreach (shadow_words[i]) shadow_words[i] = '0;

    // Directed table. Width 4 (reset value): 16 entries per word.
    add_row(7'd4,   REQ_READ,  16'd0,     64'd0,        1, 64'd0,        1'b0);
    add_row(7'd4,   REQ_READ,  16'd16383, 64'd0,        1, 64'd0,        1'b0);
    add_row(7'd4,   REQ_READ,  16'd16384, 64'd0,        1, 64'd0,        1'b1);
    add_row(7'd4,   REQ_WRITE, 16'hffff,  PBA_ALL_ONES, 1, 64'd0,        1'b1);
    add_row(7'd4,   REQ_WRITE, 16'd0,     PBA_ALL_ONES, 1, 64'd0,        1'b0);
    add_row(7'd4,   REQ_READ,  16'd0,     64'd0,        1, 64'hf,        1'b0);
    add_row(7'd4,   REQ_READ,  16'd1,     64'd0,        1, 64'd0,        1'b0);
    add_row(7'd4,   REQ_WRITE, 16'd16383, 64'd5,        1, 64'd0,        1'b0);
    add_row(7'd4,   REQ_READ,  16'd16383, 64'd0,        1, 64'd5,        1'b0);
    // Width 1: the whole 16-bit index space lies in range
    add_row(7'd1,   REQ_WRITE, 16'hffff,  64'd1,        1, 64'd0,        1'b0);
    add_row(7'd1,   REQ_READ,  16'hffff,  64'd0,        1, 64'd1,        1'b0);
    add_row(7'd1,   REQ_READ,  16'hfffe,  64'd0,        0, 64'd0,        1'b0);
    add_row(7'd1,   REQ_READ,  16'd3,     64'd0,        0, 64'd0,        1'b0);
    // Width 64: one entry per word, no masking
    add_row(7'd64,  REQ_WRITE, 16'd1023,  PBA_ALL_ONES, 1, 64'd0,        1'b0);
    add_row(7'd64,  REQ_READ,  16'd1023,  64'd0,        1, PBA_ALL_ONES, 1'b0);
    add_row(7'd64,  REQ_READ,  16'd1024,  64'd0,        1, 64'd0,        1'b1);
    add_row(7'd64,  REQ_WRITE, 16'd1024,  PBA_ALL_ONES, 1, 64'd0,        1'b1);
    add_row(7'd64,  REQ_READ,  16'd0,     64'd0,        0, 64'd0,        1'b0);
    // Zero width behaves as 1, widths over 64 as 64
    add_row(7'd0,   REQ_READ,  16'hffff,  64'd0,        0, 64'd0,        1'b0);
    add_row(7'd127, REQ_WRITE, 16'd0,     64'd0,        1, 64'd0,        1'b0);
    add_row(7'd127, REQ_READ,  16'd1023,  64'd0,        0, 64'd0,        1'b0);
    // Width 3: 21 entries per word, top bit of each word unused
    add_row(7'd3,   REQ_WRITE, 16'd20,    PBA_ALL_ONES, 1, 64'd0,        1'b0);
    add_row(7'd3,   REQ_READ,  16'd20,    64'd0,        0, 64'd0,        1'b0);
    add_row(7'd3,   REQ_READ,  16'd21,    64'd0,        0, 64'd0,        1'b0);
    add_row(7'd3,   REQ_READ,  16'd21503, 64'd0,        0, 64'd0,        1'b0);
    add_row(7'd3,   REQ_READ,  16'd21504, 64'd0,        1, 64'd0,        1'b1);

    // Single reset, then wait out the clearing pass
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (busy);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].width != shadow_width) begin
        drain_results();
        set_width(dir_rows[i].width);
      end
      issue_request(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].rsp);
    end

    // Random phases, each at its own width, written only once drained
    sent = 0;
    while (sent < N_RANDOM) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       wsel = 7'd0;
      else if (pick < 10) wsel = 7'd1;
      else if (pick < 15) wsel = 7'd64;
      else if (pick < 20) wsel = 7'($urandom_range(65, 127));
      else                wsel = 7'($urandom_range(1, 64));
      drain_results();
      set_width(wsel);
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 160);
      if (phase_len > N_RANDOM - sent) phase_len = N_RANDOM - sent;
      w   = eff_width(wsel);
      cap = WORDS * (64 / w);               // entries that fall inside the memory
      if (cap > 65536) cap = 65536;

      repeat (phase_len) begin
        r.req_type = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
        pick = $urandom_range(0, 99);
        if (pick < 45 && hot_idx.size() != 0)
          r.index = hot_idx[$urandom_range(0, hot_idx.size() - 1)];
        else if (pick < 80)
          r.index = 16'($urandom_range(0, cap - 1));
        else if (pick < 90 && cap < 65536)
          r.index = 16'($urandom_range(cap - 2, cap));   // straddle the memory end
        else
          r.index = 16'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 7)       r.write_value = {$urandom, $urandom};
        else if (pick == 7) r.write_value = PBA_ALL_ONES;
        else if (pick == 8) r.write_value = '0;
        else                r.write_value = 64'($urandom_range(0, 255));
        if (r.req_type == REQ_WRITE && r.index < cap) begin
          hot_idx.push_back(r.index);
          if (hot_idx.size() > HOT_DEPTH) void'(hot_idx.pop_front());
        end
        issue_request(r, 0, none);
        sent++;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    fail_count += entry_rsp_q.size();      // anything still owed is a failure

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, clearing pass included
  initial begin : watchdog
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
